// ----- sv/amd_pkg.sv -----
// Shared types, register indexes and fixed-point helpers of the admittance axis core.
package amd_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] CfgInvLinMass  = 3'd0;
    localparam logic [2:0] CfgLinDamping  = 3'd1;
    localparam logic [2:0] CfgInvAngMass  = 3'd2;
    localparam logic [2:0] CfgAngDamping  = 3'd3;
    localparam logic [2:0] CfgTargetForce = 3'd4;
    localparam logic [2:0] CfgSpeedLimit  = 3'd5;
    localparam logic [2:0] CfgDeadband    = 3'd6;

    // Axis that carries the target contact force
    localparam logic [2:0] AxisForceZ  = 3'd2;

    // Number of register stages from input beat to output beat
    localparam int unsigned PipeDepth = 7;

    // Configuration register file
    typedef struct packed {
        logic [30:0]        inv_lin_mass;
        logic [30:0]        lin_damping;
        logic [30:0]        inv_ang_mass;
        logic [30:0]        ang_damping;
        logic signed [31:0] target_force_z;
        logic [30:0]        speed_limit;
        logic [30:0]        speed_deadband;
    } amd_cfg_t;

    // Input beat
    typedef struct packed {
        logic [2:0]         axis;
        logic signed [31:0] wrench;
        logic signed [31:0] speed;
        logic signed [31:0] position;
        logic [15:0]        dt;
    } amd_in_t;

    // Between damping and acceleration sections
    typedef struct packed {
        logic [2:0]         axis;
        logic signed [31:0] diff;
        logic [30:0]        inv_m;
        logic signed [31:0] speed;
        logic signed [31:0] position;
        logic [15:0]        dt;
    } amd_mid_t;

    // Between acceleration and integration sections
    typedef struct packed {
        logic [2:0]         axis;
        logic signed [63:0] dv_prod;
        logic signed [31:0] speed;
        logic signed [31:0] position;
        logic [15:0]        dt;
    } amd_acc_t;

    // Result beat
    typedef struct packed {
        logic [2:0]         axis;
        logic signed [31:0] cmd_speed;
        logic signed [31:0] cmd_position;
    } amd_out_t;

    // Saturate an exact 33-bit sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
        logic signed [31:0] r;
        if (s[32] == s[31]) begin
            r = s[31:0];
        end else if (s[32]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Q16.16 product: floor of p / 2^16, saturated to 32 bits
    function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
        logic signed [47:0] q;
        logic signed [31:0] r;
        q = p[63:16];
        if (&q[47:31] || ~|q[47:31]) begin
            r = q[31:0];
        end else if (q[47]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Signed 32-bit value times unsigned 31-bit coefficient, exact
    function automatic logic signed [63:0] mul_su31(input logic signed [31:0] a,
                                                    input logic [30:0] b);
        logic signed [63:0] ax;
        logic signed [63:0] bx;
        ax = {{32{a[31]}}, a};
        bx = {33'd0, b};
        return ax * bx;
    endfunction

    // Signed 32-bit value times unsigned 16-bit step, exact
    function automatic logic signed [63:0] mul_su16(input logic signed [31:0] a,
                                                    input logic [15:0] b);
        logic signed [63:0] ax;
        logic signed [63:0] bx;
        ax = {{32{a[31]}}, a};
        bx = {48'd0, b};
        return ax * bx;
    endfunction

endpackage

// ----- sv/amd_damp_stage.sv -----
// Damping section: force error, damping product and force difference (two stages).
module amd_damp_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  amd_pkg::amd_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  amd_pkg::amd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output amd_pkg::amd_mid_t out_data
);
    import amd_pkg::*;

    logic               v1_reg, v2_reg;
    logic               en1, en2;
    logic               linear;
    logic signed [31:0] err_next;
    logic signed [63:0] dprod_next;
    logic signed [31:0] dforce;

    // Stage 1 payload
    logic [2:0]         axis1_reg;
    logic signed [31:0] err1_reg;
    logic signed [63:0] dprod1_reg;
    logic [30:0]        invm1_reg;
    logic signed [31:0] spd1_reg, pos1_reg;
    logic [15:0]        dt1_reg;

    amd_mid_t           mid_reg;
    amd_mid_t           mid_next;

    // Stage enables: a stage moves when empty or when the next one moves
    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Axis selection, target force and damping product
    always_comb begin
        linear     = (in_data.axis <= AxisForceZ);
        err_next   = in_data.wrench;
        if (in_data.axis == AxisForceZ) begin
            err_next = sat33({in_data.wrench[31], in_data.wrench}
                             - {cfg.target_force_z[31], cfg.target_force_z});
        end
        dprod_next = mul_su31(in_data.speed, linear ? cfg.lin_damping : cfg.ang_damping);
    end

    // Damping force in Q16.16
    assign dforce = mulq(dprod1_reg);

    // Force minus damping force
    always_comb begin
        mid_next.axis     = axis1_reg;
        mid_next.diff     = sat33({err1_reg[31], err1_reg} - {dforce[31], dforce});
        mid_next.inv_m    = invm1_reg;
        mid_next.speed    = spd1_reg;
        mid_next.position = pos1_reg;
        mid_next.dt       = dt1_reg;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en1) begin
            axis1_reg  <= in_data.axis;
            err1_reg   <= err_next;
            dprod1_reg <= dprod_next;
            invm1_reg  <= (in_data.axis <= AxisForceZ) ? cfg.inv_lin_mass : cfg.inv_ang_mass;
            spd1_reg   <= in_data.speed;
            pos1_reg   <= in_data.position;
            dt1_reg    <= in_data.dt;
        end
        if (en2) begin
            mid_reg <= mid_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = mid_reg;

endmodule

// ----- sv/amd_accel_stage.sv -----
// Acceleration section: inverse mass product, then acceleration times step (two stages).
module amd_accel_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  amd_pkg::amd_mid_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output amd_pkg::amd_acc_t out_data
);
    import amd_pkg::*;

    logic               v1_reg, v2_reg;
    logic               en1, en2;

    // Stage 1 payload
    logic [2:0]         axis1_reg;
    logic signed [63:0] aprod1_reg;
    logic signed [31:0] spd1_reg, pos1_reg;
    logic [15:0]        dt1_reg;

    amd_acc_t           acc_reg;
    amd_acc_t           acc_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Acceleration, then its product with the time step
    always_comb begin
        acc_next.axis     = axis1_reg;
        acc_next.dv_prod  = mul_su16(mulq(aprod1_reg), dt1_reg);
        acc_next.speed    = spd1_reg;
        acc_next.position = pos1_reg;
        acc_next.dt       = dt1_reg;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en1) begin
            axis1_reg  <= in_data.axis;
            aprod1_reg <= mul_su31(in_data.diff, in_data.inv_m);
            spd1_reg   <= in_data.speed;
            pos1_reg   <= in_data.position;
            dt1_reg    <= in_data.dt;
        end
        if (en2) begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = acc_reg;

endmodule

// ----- sv/amd_integ_stage.sv -----
// Integration section: commanded velocity, pose product, pose sum, deadband and clamp.
module amd_integ_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  amd_pkg::amd_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  amd_pkg::amd_acc_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output amd_pkg::amd_out_t out_data
);
    import amd_pkg::*;

    logic               v1_reg, v2_reg, v3_reg;
    logic               en1, en2, en3;

    // Stage 1: unlimited commanded velocity
    logic [2:0]         axis1_reg;
    logic signed [31:0] cmdv1_reg, pos1_reg;
    logic [15:0]        dt1_reg;

    // Stage 2: pose increment product
    logic [2:0]         axis2_reg;
    logic signed [31:0] cmdv2_reg, pos2_reg;
    logic signed [63:0] pprod2_reg;

    amd_out_t           out_reg;
    amd_out_t           out_next;

    logic signed [32:0] mag;
    logic signed [32:0] lim;
    logic signed [31:0] outv;
    logic signed [31:0] vinc;
    logic signed [31:0] pinc;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign vinc = mulq(in_data.dv_prod);
    assign pinc = mulq(pprod2_reg);

    // Pose sum, deadband then symmetric clamp on velocity
    always_comb begin
        mag  = cmdv2_reg[31] ? -{cmdv2_reg[31], cmdv2_reg} : {cmdv2_reg[31], cmdv2_reg};
        lim  = {2'b00, cfg.speed_limit};
        outv = cmdv2_reg;
        if (mag < $signed({2'b00, cfg.speed_deadband})) begin
            outv = 32'sd0;
        end
        if ($signed({outv[31], outv}) > lim) begin
            outv = lim[31:0];
        end else if ($signed({outv[31], outv}) < -lim) begin
            outv = -$signed({1'b0, cfg.speed_limit});
        end
        out_next.axis         = axis2_reg;
        out_next.cmd_speed    = outv;
        out_next.cmd_position = sat33({pos2_reg[31], pos2_reg} - 33'sd0
                                      + {pinc[31], pinc});
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en1) begin
            axis1_reg <= in_data.axis;
            cmdv1_reg <= sat33({in_data.speed[31], in_data.speed} + {vinc[31], vinc});
            pos1_reg  <= in_data.position;
            dt1_reg   <= in_data.dt;
        end
        if (en2) begin
            axis2_reg  <= axis1_reg;
            cmdv2_reg  <= cmdv1_reg;
            pos2_reg   <= pos1_reg;
            pprod2_reg <= mul_su16(cmdv1_reg, dt1_reg);
        end
        if (en3) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

// ----- sv/admittance_mass_damper_axis_core.sv -----
// Top level of the per-axis admittance (mass-damper) core with stream ports.
//
// One input beat carries one axis: s_tuser holds the axis number, s_tdata the
// measured force or torque, actual velocity, actual pose and the time step.
// One result beat comes out per input beat, in order: m_tuser echoes the
// axis, m_tdata holds the commanded velocity (after deadband and clamp) and
// the commanded pose. Force, velocity and pose are signed Q16.16 with saturation;
// the time step is unsigned Q0.16. One beat is taken per cycle while m_tready does
// not hold the pipeline full. The four chained multiplies (damping, inverse
// mass, two step products) each have a register after them, as do the sums,
// deadband and clamp between them.
// Each stage holds its beat when the one after it is full and held, so a stall on
// m_tready backs up stage by stage; empty stages keep filling meanwhile.
// Configuration writes on the cfg_ channel are always taken (cfg_ready high)
// and must be made only while no beat is in flight. Reset (aresetn low,
// synchronous) empties the pipeline and loads the default coefficients.
module admittance_mass_damper_axis_core (
    input  logic         aclk,
    input  logic         aresetn,
    // Input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // meas_wrench[31:0], meas_speed[63:32],
                                    // meas_position[95:64], time_step[111:96]
    input  logic [2:0]   s_tuser,   // axis_index[2:0]
    // Result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // cmd_speed[31:0], cmd_position[63:32]
    output logic [2:0]   m_tuser,   // out_axis[2:0]
    // Configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import amd_pkg::*;

    amd_cfg_t cfg_reg;
    amd_in_t  in_beat;
    amd_mid_t mid_data;
    amd_acc_t acc_data;
    amd_out_t out_data;
    logic     mid_valid, mid_ready;
    logic     acc_valid, acc_ready;
    logic     in_acc, out_acc;
    logic [2:0] occ_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_lin_mass   <= 31'd13107;
            cfg_reg.lin_damping    <= 31'd655360;
            cfg_reg.inv_ang_mass   <= 31'd65536;
            cfg_reg.ang_damping    <= 31'd131072;
            cfg_reg.target_force_z <= 32'sd65536;
            cfg_reg.speed_limit    <= 31'd65536;
            cfg_reg.speed_deadband <= 31'd66;
        end else if (cfg_valid) begin
            case (cfg_index)
                CfgInvLinMass:  cfg_reg.inv_lin_mass   <= cfg_data[30:0];
                CfgLinDamping:  cfg_reg.lin_damping    <= cfg_data[30:0];
                CfgInvAngMass:  cfg_reg.inv_ang_mass   <= cfg_data[30:0];
                CfgAngDamping:  cfg_reg.ang_damping    <= cfg_data[30:0];
                CfgTargetForce: cfg_reg.target_force_z <= cfg_data;
                CfgSpeedLimit:  cfg_reg.speed_limit    <= cfg_data[30:0];
                CfgDeadband:    cfg_reg.speed_deadband <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Unpack input beat
    assign in_beat.axis     = s_tuser;
    assign in_beat.wrench   = s_tdata[31:0];
    assign in_beat.speed    = s_tdata[63:32];
    assign in_beat.position = s_tdata[95:64];
    assign in_beat.dt       = s_tdata[111:96];

    amd_damp_stage u_damp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_beat),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    amd_accel_stage u_accel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_data  (acc_data)
    );

    amd_integ_stage u_integ (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .in_data   (acc_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack result beat
    assign m_tuser = out_data.axis;
    assign m_tdata = {out_data.cmd_position, out_data.cmd_speed};

    // Beats in flight, for checking only
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 3'd0;
        end else if (in_acc && !out_acc) begin
            occ_reg <= occ_reg + 3'd1;
        end else if (out_acc && !in_acc) begin
            occ_reg <= occ_reg - 3'd1;
        end
    end

    // Backpressure only comes from a stalled result beat
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a stalled result beat");

    // An empty pipeline shows no result
    a_empty_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg == 3'd0) |-> !m_tvalid)
        else $error("result beat with no beat in flight");

    // A full pipeline under stall takes no new beat
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((occ_reg == 3'(PipeDepth)) && !m_tready) |-> !s_tready)
        else $error("beat accepted into a full stalled pipeline");

endmodule

// ----- verif/tb_admittance_mass_damper_axis_core.sv -----
// Self-checking testbench of the per-axis admittance core: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_admittance_mass_damper_axis_core;
    import amd_pkg::*;

    // Run control
    localparam int unsigned CycleLimit   = 400000;
    localparam int unsigned PhaseCount   = 8;
    localparam int unsigned BeatsPerPhase = 80;
    // Index past the register file, written to check it is ignored
    localparam logic [2:0]  CfgUnused    = 3'd7;

    // Coefficient defaults after reset
    localparam logic [30:0]        RstInvLinMass  = 31'd13107;
    localparam logic [30:0]        RstLinDamping  = 31'd655360;
    localparam logic [30:0]        RstInvAngMass  = 31'd65536;
    localparam logic [30:0]        RstAngDamping  = 31'd131072;
    localparam logic signed [31:0] RstTargetForce = 32'sd65536;
    localparam logic [30:0]        RstSpeedLimit  = 31'd65536;
    localparam logic [30:0]        RstDeadband    = 31'd66;

    localparam logic [31:0] S32Max = 32'h7FFF_FFFF;
    localparam logic [31:0] S32Min = 32'h8000_0000;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata   = '0;
    logic [2:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data  = '0;

    admittance_mass_damper_axis_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    amd_cfg_t    coeffs;              // predictor copy of the register file
    amd_in_t     axis_beats_q[$];     // beats waiting to be driven
    amd_out_t    pending_commands[$]; // predicted commands, oldest first
    amd_in_t     driven_beat;
    amd_in_t     fresh_beat;
    amd_out_t    want;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_mode  = 0;
    int unsigned stall_tick  = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    // Saturate to signed 32 bits
    function automatic longint clip32(input longint x);
        if (x > longint'($signed(S32Max))) return longint'($signed(S32Max));
        if (x < longint'($signed(S32Min))) return longint'($signed(S32Min));
        return x;
    endfunction

    // Q16.16 product: exact, floor shift, then saturate
    function automatic longint qmul(input longint a, input longint b);
        return clip32((a * b) >>> 16);
    endfunction

    // Expected command of one axis beat under the current coefficients
    function automatic amd_out_t admittance_command(input amd_in_t beat);
        logic     linear;
        longint   inv_m;
        longint   damp;
        longint   force_err;
        longint   diff;
        longint   accel;
        longint   vel_cmd;
        longint   pos_cmd;
        longint   mag;
        longint   speed_out;
        longint   lim;
        amd_out_t res;
        // axes x, y, z are linear; everything above is angular
        linear    = (beat.axis <= AxisForceZ);
        inv_m     = linear ? longint'(coeffs.inv_lin_mass) : longint'(coeffs.inv_ang_mass);
        damp      = linear ? longint'(coeffs.lin_damping) : longint'(coeffs.ang_damping);
        force_err = longint'(beat.wrench);
        if (beat.axis == AxisForceZ)
            force_err = clip32(force_err - longint'(coeffs.target_force_z));
        diff    = clip32(force_err - qmul(damp, longint'(beat.speed)));
        accel   = qmul(inv_m, diff);
        vel_cmd = clip32(longint'(beat.speed) + qmul(accel, longint'(beat.dt)));
        pos_cmd = clip32(longint'(beat.position) + qmul(vel_cmd, longint'(beat.dt)));
        // deadband first, then the symmetric clamp
        speed_out = vel_cmd;
        mag       = (vel_cmd < 0) ? -vel_cmd : vel_cmd;
        if (mag < longint'(coeffs.speed_deadband))
            speed_out = 0;
        lim = longint'(coeffs.speed_limit);
        if (speed_out > lim)
            speed_out = lim;
        else if (speed_out < -lim)
            speed_out = -lim;
        res.axis         = beat.axis;
        res.cmd_speed    = 32'(speed_out);
        res.cmd_position = 32'(pos_cmd);
        return res;
    endfunction

    // Random Q16.16 value: full range, small, moderate or an extreme
    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 1 << 21) - (1 << 20);
            2: begin
                case ($urandom_range(0, 4))
                    0: v = S32Max;
                    1: v = S32Min;
                    2: v = 32'h0;
                    3: v = 32'h1;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom_range(0, 1 << 25) - (1 << 24);
        endcase
        return v;
    endfunction

    task automatic add_beat(input logic [2:0] axis, input logic [31:0] wrench,
                            input logic [31:0] speed, input logic [31:0] position,
                            input logic [15:0] dt);
        amd_in_t b;
        b.axis     = axis;
        b.wrench   = wrench;
        b.speed    = speed;
        b.position = position;
        b.dt       = dt;
        axis_beats_q.push_back(b);
    endtask

    // One register write; the predictor copy follows at the accepting edge
    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CfgInvLinMass:  coeffs.inv_lin_mass   = data[30:0];
            CfgLinDamping:  coeffs.lin_damping    = data[30:0];
            CfgInvAngMass:  coeffs.inv_ang_mass   = data[30:0];
            CfgAngDamping:  coeffs.ang_damping    = data[30:0];
            CfgTargetForce: coeffs.target_force_z = data;
            CfgSpeedLimit:  coeffs.speed_limit    = data[30:0];
            CfgDeadband:    coeffs.speed_deadband = data[30:0];
            default: ;
        endcase
    endtask

    // Wait until every beat is driven and every command has come back
    task automatic wait_drained();
        @(negedge aclk);
        while (axis_beats_q.size() != 0 || s_tvalid || pending_commands.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Driver: bursts of beats with random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready)
                pending_commands.push_back(admittance_command(driven_beat));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (axis_beats_q.size() > 0) begin
                    fresh_beat  = axis_beats_q.pop_front();
                    driven_beat = fresh_beat;
                    s_tvalid <= 1'b1;
                    s_tuser  <= fresh_beat.axis;
                    s_tdata  <= {fresh_beat.dt, fresh_beat.position,
                                 fresh_beat.speed, fresh_beat.wrench};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat, stall m_tready in changing modes
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_commands.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected beat: expected none, actual axis %0d speed %0d pos %0d",
                             $time, m_tuser, $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                end else begin
                    want = pending_commands.pop_front();
                    if (m_tuser !== want.axis) begin
                        error_count++;
                        $display("%0t axis mismatch: expected %0d actual %0d",
                                 $time, want.axis, m_tuser);
                    end
                    if (m_tdata[31:0] !== want.cmd_speed) begin
                        error_count++;
                        $display("%0t cmd_speed mismatch: expected %0d actual %0d",
                                 $time, want.cmd_speed, $signed(m_tdata[31:0]));
                    end
                    if (m_tdata[63:32] !== want.cmd_position) begin
                        error_count++;
                        $display("%0t cmd_position mismatch: expected %0d actual %0d",
                                 $time, want.cmd_position, $signed(m_tdata[63:32]));
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(10, 80);
            end else begin
                stall_left--;
            end
            stall_tick++;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((stall_tick % 5) < 2);
            endcase
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus: reset, directed beats, then random phases with new coefficients
    initial begin
        logic [31:0] r_inv_lin;
        logic [31:0] r_lin_damp;
        logic [31:0] r_inv_ang;
        logic [31:0] r_ang_damp;
        logic [31:0] r_target;
        logic [31:0] r_limit;
        logic [31:0] r_deadband;
        logic [15:0] dt_pick;
        coeffs.inv_lin_mass   = RstInvLinMass;
        coeffs.lin_damping    = RstLinDamping;
        coeffs.inv_ang_mass   = RstInvAngMass;
        coeffs.ang_damping    = RstAngDamping;
        coeffs.target_force_z = RstTargetForce;
        coeffs.speed_limit    = RstSpeedLimit;
        coeffs.speed_deadband = RstDeadband;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every axis code, including the two beyond the arm
        for (int a = 0; a < 8; a++)
            add_beat(3'(a), 32'd196608, 32'd16384, 32'd65536, 16'd66);
        // field extremes
        add_beat(3'd0, S32Max, S32Min, S32Max, 16'hFFFF);
        add_beat(3'd3, S32Min, S32Max, S32Min, 16'hFFFF);
        // target subtraction on z saturating low, and z at full force
        add_beat(AxisForceZ, S32Min, 32'd0, 32'd0, 16'd1000);
        add_beat(AxisForceZ, S32Max, 32'd1, 32'd0, 16'hFFFF);
        // deadband: zero, just under, exactly at the threshold
        add_beat(3'd1, 32'd0, 32'd0, 32'd0, 16'd0);
        add_beat(3'd0, 32'd0, 32'd50, 32'd0, 16'd0);
        add_beat(3'd4, 32'd0, -32'sd66, 32'd0, 16'd0);
        // clamp both ways
        add_beat(3'd1, 32'd0, 32'd200000, 32'd0, 16'd0);
        add_beat(3'd5, 32'd0, -32'sd200000, 32'd0, 16'd0);
        // pose saturation
        add_beat(3'd4, 32'd0, S32Max, S32Max, 16'hFFFF);
        add_beat(3'd5, 32'd0, S32Min, S32Min, 16'hFFFF);
        add_beat(3'd7, S32Max, S32Max, S32Max, 16'd0);
        wait_drained();

        for (int phase = 0; phase < PhaseCount; phase++) begin
            case (phase)
                0: begin
                    // all coefficients at their top, bit 31 set on the unsigned ones to check masking
                    r_inv_lin  = 32'hFFFF_FFFF;
                    r_lin_damp = 32'hFFFF_FFFF;
                    r_inv_ang  = 32'hFFFF_FFFF;
                    r_ang_damp = 32'hFFFF_FFFF;
                    r_target   = S32Max;
                    r_limit    = 32'hFFFF_FFFF;
                    r_deadband = 32'hFFFF_FFFF;
                end
                1: begin
                    r_inv_lin  = 32'd0;
                    r_lin_damp = 32'd0;
                    r_inv_ang  = 32'd0;
                    r_ang_damp = 32'd0;
                    r_target   = S32Min;
                    r_limit    = 32'd0;
                    r_deadband = 32'd0;
                end
                2: begin
                    r_inv_lin  = 32'(RstInvLinMass);
                    r_lin_damp = 32'(RstLinDamping);
                    r_inv_ang  = 32'(RstInvAngMass);
                    r_ang_damp = 32'(RstAngDamping);
                    r_target   = RstTargetForce;
                    r_limit    = 32'(RstSpeedLimit);
                    r_deadband = 32'(RstDeadband);
                end
                PhaseCount - 1: begin
                    r_inv_lin  = $urandom;
                    r_lin_damp = $urandom;
                    r_inv_ang  = $urandom;
                    r_ang_damp = $urandom;
                    r_target   = $urandom;
                    r_limit    = $urandom;
                    r_deadband = $urandom;
                end
                default: begin
                    // plausible tuning values
                    r_inv_lin  = $urandom_range(0, 1 << 18);
                    r_lin_damp = $urandom_range(0, 1 << 22);
                    r_inv_ang  = $urandom_range(0, 1 << 18);
                    r_ang_damp = $urandom_range(0, 1 << 22);
                    r_target   = rand_value();
                    r_limit    = $urandom_range(1 << 12, 1 << 22);
                    r_deadband = $urandom_range(0, 1 << 12);
                end
            endcase
            write_register(CfgInvLinMass, r_inv_lin);
            write_register(CfgLinDamping, r_lin_damp);
            write_register(CfgInvAngMass, r_inv_ang);
            write_register(CfgAngDamping, r_ang_damp);
            write_register(CfgTargetForce, r_target);
            write_register(CfgSpeedLimit, r_limit);
            write_register(CfgDeadband, r_deadband);
            write_register(CfgUnused, $urandom);

            for (int n = 0; n < BeatsPerPhase; n++) begin
                case ($urandom_range(0, 3))
                    0: dt_pick = 16'($urandom);
                    1: dt_pick = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'hFFFF;
                    default: dt_pick = 16'($urandom_range(1, 700));
                endcase
                add_beat(3'($urandom_range(0, 7)), rand_value(), rand_value(), rand_value(),
                         dt_pick);
            end
            // sender holds off until every command of this phase is back
            wait_drained();
        end

        repeat (PipeDepth + 8) @(posedge aclk);
        if (error_count == 0 && pending_commands.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
